@@ sv/i2cbs_pkg.sv @@
// Shared types and constants for the I2C master bit sequencer.
// Used by the front, the back and the top level; depends on nothing.
package i2cbs_pkg;

   typedef enum logic [2:0] {
      OP_START   = 3'd0,
      OP_STOP    = 3'd1,
      OP_WRITE   = 3'd2,
      OP_READ    = 3'd3,
      OP_ACK     = 3'd4,
      OP_NACK    = 3'd5,
      OP_WAITACK = 3'd6,
      OP_TICK    = 3'd7
   } op_type;

   // The active command register holds the tick code when no command runs.
   localparam op_type CMD_IDLE = OP_TICK;

   localparam int QUEUE_DEPTH = 2;
   localparam int IDX_W       = 5;
   localparam int BYTE_W      = 8;

   localparam logic [IDX_W-1:0] WRITE_LAST_IDX = IDX_W'(23);
   localparam logic [IDX_W-1:0] READ_LAST_IDX  = IDX_W'(16);

   typedef struct packed {
      logic              is_tick;
      op_type            op;
      logic [BYTE_W-1:0] data_byte;
      logic              sda_in;
   } entry_type;

   typedef struct packed {
      op_type           cmd;
      logic [IDX_W-1:0] idx;
   } back_status_type;

endpackage

@@ sv/i2cbs_front.sv @@
// Front of the I2C master bit sequencer: accepts request words, classifies
// them as tick or command and holds them in a short queue. Uses i2cbs_pkg.
module i2cbs_front #(
   parameter int Depth = i2cbs_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_op,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_sda_in,
   output logic                  q_valid,
   output i2cbs_pkg::entry_type  q_entry,
   input  logic                  q_pop
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   i2cbs_pkg::entry_type entries_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   i2cbs_pkg::entry_type new_entry;
   logic push;

   always_comb begin
      new_entry.op        = i2cbs_pkg::op_type'(req_op);
      new_entry.is_tick   = (new_entry.op == i2cbs_pkg::OP_TICK);
      new_entry.data_byte = req_data_byte;
      new_entry.sda_in    = req_sda_in;
   end

   assign req_ready = (count_ff != FullCnt);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign q_entry   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !q_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (q_pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

@@ sv/i2cbs_back.sv @@
// Back of the I2C master bit sequencer: latches a command when none is active,
// applies one pin event per tick word while a command runs and holds the result
// word in an output register. Uses i2cbs_pkg.
module i2cbs_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  i2cbs_pkg::entry_type        q_entry,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_scl_level,
   output logic                        rsp_sda_level,
   output logic                        rsp_busy_res,
   output logic [7:0]                  rsp_received_byte,
   output logic                        rsp_ack_bit,
   output logic                        rsp_done_res,
   output i2cbs_pkg::back_status_type  status
);

   localparam int IdxW  = i2cbs_pkg::IDX_W;
   localparam int ByteW = i2cbs_pkg::BYTE_W;

   i2cbs_pkg::op_type cmd_ff, cmd_in;
   logic [IdxW-1:0]  idx_ff, idx_in;
   logic [1:0]       phase_ff, phase_in;
   logic [ByteW-1:0] tx_ff, tx_in;
   logic [ByteW-1:0] rx_ff, rx_in;
   logic [ByteW-1:0] rsp_rx_ff, rsp_rx_in;
   logic             ack_ff, ack_in;
   logic             scl_ff, scl_in;
   logic             sda_ff, sda_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             done_ff, done_in;
   logic             busy_ff, busy_in;
   logic             last;
   logic             tick_go;

   assign q_pop   = q_valid && (!q_entry.is_tick || !rsp_valid_ff || rsp_ready);
   assign tick_go = q_pop && q_entry.is_tick;

   always_comb begin
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      phase_in     = phase_ff;
      tx_in        = tx_ff;
      rx_in        = rx_ff;
      rsp_rx_in    = rsp_rx_ff;
      ack_in       = ack_ff;
      scl_in       = scl_ff;
      sda_in       = sda_ff;
      last         = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      done_in      = done_ff;
      busy_in      = busy_ff;

      if (q_pop && !q_entry.is_tick) begin
         if (cmd_ff == i2cbs_pkg::CMD_IDLE) begin
            cmd_in   = q_entry.op;
            idx_in   = '0;
            phase_in = 2'd0;
            if (q_entry.op == i2cbs_pkg::OP_WRITE) begin
               tx_in = q_entry.data_byte;
            end
            if (q_entry.op == i2cbs_pkg::OP_READ) begin
               rx_in = '0;
            end
         end
      end

      if (tick_go && cmd_ff != i2cbs_pkg::CMD_IDLE) begin
         case (cmd_ff)
            i2cbs_pkg::OP_START: begin
               case (idx_ff)
                  IdxW'(0): sda_in = 1'b1;
                  IdxW'(1): scl_in = 1'b1;
                  IdxW'(2): sda_in = 1'b0;
                  default: begin
                     scl_in = 1'b0;
                     last   = 1'b1;
                  end
               endcase
            end
            i2cbs_pkg::OP_STOP: begin
               case (idx_ff)
                  IdxW'(0): sda_in = 1'b0;
                  IdxW'(1): scl_in = 1'b1;
                  default: begin
                     sda_in = 1'b1;
                     last   = 1'b1;
                  end
               endcase
            end
            i2cbs_pkg::OP_WRITE: begin
               case (phase_ff)
                  2'd0: sda_in = tx_ff[ByteW-1];
                  2'd1: scl_in = 1'b1;
                  default: begin
                     scl_in = 1'b0;
                     tx_in  = {tx_ff[ByteW-2:0], 1'b0};
                     last   = (idx_ff >= i2cbs_pkg::WRITE_LAST_IDX);
                  end
               endcase
               phase_in = (phase_ff == 2'd2) ? 2'd0 : phase_ff + 2'd1;
            end
            i2cbs_pkg::OP_READ: begin
               if (idx_ff == '0) begin
                  sda_in = 1'b1;
               end else if (idx_ff[0]) begin
                  scl_in = 1'b1;
               end else begin
                  rx_in  = {rx_ff[ByteW-2:0], q_entry.sda_in};
                  scl_in = 1'b0;
                  last   = (idx_ff >= i2cbs_pkg::READ_LAST_IDX);
               end
            end
            i2cbs_pkg::OP_ACK, i2cbs_pkg::OP_NACK: begin
               case (idx_ff)
                  IdxW'(0): sda_in = (cmd_ff == i2cbs_pkg::OP_NACK);
                  IdxW'(1): scl_in = 1'b1;
                  default: begin
                     scl_in = 1'b0;
                     last   = 1'b1;
                  end
               endcase
            end
            i2cbs_pkg::OP_WAITACK: begin
               case (idx_ff)
                  IdxW'(0): sda_in = 1'b1;
                  IdxW'(1): scl_in = 1'b1;
                  default: begin
                     ack_in = q_entry.sda_in;
                     scl_in = 1'b0;
                     last   = 1'b1;
                  end
               endcase
            end
            default: last = 1'b1;
         endcase
         if (last) begin
            cmd_in = i2cbs_pkg::CMD_IDLE;
            idx_in = '0;
         end else begin
            idx_in = idx_ff + IdxW'(1);
         end
      end

      if (tick_go) begin
         rsp_valid_in = 1'b1;
         done_in      = last;
         busy_in      = (cmd_in != i2cbs_pkg::CMD_IDLE);
         rsp_rx_in    = rx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff       <= i2cbs_pkg::CMD_IDLE;
         idx_ff       <= '0;
         phase_ff     <= 2'd0;
         tx_ff        <= '0;
         rx_ff        <= '0;
         rsp_rx_ff    <= '0;
         ack_ff       <= 1'b1;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmd_ff       <= cmd_in;
         idx_ff       <= idx_in;
         phase_ff     <= phase_in;
         tx_ff        <= tx_in;
         rx_ff        <= rx_in;
         rsp_rx_ff    <= rsp_rx_in;
         ack_ff       <= ack_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      done_ff <= done_in;
      busy_ff <= busy_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_scl_level     = scl_ff;
   assign rsp_sda_level     = sda_ff;
   assign rsp_busy_res      = busy_ff;
   assign rsp_received_byte = rsp_rx_ff;
   assign rsp_ack_bit       = ack_ff;
   assign rsp_done_res      = done_ff;

   assign status.cmd = cmd_ff;
   assign status.idx = idx_ff;

endmodule

@@ sv/i2c_master_bit_sequencer.sv @@
// Top level of the I2C master bit sequencer: the front queue and the back.
// Depends on i2cbs_pkg, i2cbs_front and i2cbs_back.
//
//   channel   direction   ports                                 word
//   req       in          req_valid/ready, op, data_byte, sda   command or tick
//   rsp       out         rsp_valid/ready, levels and status    one per tick
//
// Each request word is registered in the queue, and a tick's result word is then
// registered in the back's output register; one word is taken each cycle while
// results are taken. Command words give no result word.
// Reset is synchronous and leaves both pins released and no command active.
// A stalled result register holds back only tick words; commands at the head of the queue still drain.
module i2c_master_bit_sequencer #(
   parameter int QueueDepth = i2cbs_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_op,
   input  logic [7:0] req_data_byte,
   input  logic       req_sda_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_scl_level,
   output logic       rsp_sda_level,
   output logic       rsp_busy_res,
   output logic [7:0] rsp_received_byte,
   output logic       rsp_ack_bit,
   output logic       rsp_done_res
);

   logic                       q_valid;
   logic                       q_pop;
   i2cbs_pkg::entry_type       q_entry;
   i2cbs_pkg::back_status_type status;

   i2cbs_front #(
      .Depth (QueueDepth)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_data_byte (req_data_byte),
      .req_sda_in    (req_sda_in),
      .q_valid       (q_valid),
      .q_entry       (q_entry),
      .q_pop         (q_pop)
   );

   i2cbs_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_entry           (q_entry),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_scl_level     (rsp_scl_level),
      .rsp_sda_level     (rsp_sda_level),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_received_byte (rsp_received_byte),
      .rsp_ack_bit       (rsp_ack_bit),
      .rsp_done_res      (rsp_done_res),
      .status            (status)
   );

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("result word is both done and busy");

   a_write_idx: assert property (@(posedge clock) disable iff (reset)
      status.cmd == i2cbs_pkg::OP_WRITE |-> status.idx <= i2cbs_pkg::WRITE_LAST_IDX)
      else $error("write byte ran past its last event");

   a_read_idx: assert property (@(posedge clock) disable iff (reset)
      status.cmd == i2cbs_pkg::OP_READ |-> status.idx <= i2cbs_pkg::READ_LAST_IDX)
      else $error("read byte ran past its last event");

endmodule
